// ----- design/lgs_pkg.sv -----
package lgs_pkg;

  // Configuration port geometry
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_ROWS    = 2'd1;

  localparam logic [CfgDataW-1:0] GridColumnsReset = 6'd20;
  localparam logic [CfgDataW-1:0] GridRowsReset    = 6'd20;

  // Population field width
  localparam int PopW = 11;

  // Output queue depth
  localparam int OutDepth = 4;

  typedef struct packed {
    logic            next_alive;
    logic            frame_last;
    logic [PopW-1:0] population;
  } out_item_t;

  // B3/S23 applied to the center (bit 4) of a 3x3 window
  function automatic logic life_rule(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n = n + 4'(w[i]);
      end
    end
    return (n == 4'd3) || (w[4] && (n == 4'd2));
  endfunction

endpackage

// ----- design/life_generation_stream.sv -----
// Streaming Game of Life engine, rule B3/S23, one cell per item.
// Input channel: in_valid_i / in_stall_o carry cell_alive_i, the cells of one
// generation in raster order (grid_columns cells per row, grid_rows rows).
// Output channel: out_valid_o / out_stall_i carry next_alive_o in the same
// raster order; frame_last_o marks the final cell of a generation and
// population_o then holds its live-cell count (zero on all other items).
// Cells outside the grid count as dead.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is grid_columns, index 1 grid_rows. A valid write to either
// register restarts the generation. Write only while the block is idle.
// Throughput: one item per cycle while in_stall_o is low, set by the single
// read-modify-write port pair of the two-line store. The result for a cell
// leaves one row plus one cell of input behind it. After the last cell of a
// generation the input stalls while the engine feeds a dead border row and a
// tail step and emits the remaining results.
// A full output queue stalls the input; nothing is dropped.
// Reset: grid size returns to 20 x 20, position, window and tally clear.
// No clearing pass is needed: line entries are written before being read.
module life_generation_stream #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cell_alive_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           next_alive_o,
  output logic                           frame_last_o,
  output logic [lgs_pkg::PopW-1:0]       population_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lgs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lgs_pkg::CfgDataW-1:0]   cfg_data_i
);

  import lgs_pkg::*;

  // Columns saturate at 31 so a flush never exceeds 32 results
  localparam int ColLimit = (MAX_COLUMNS > 31) ? 31 : MAX_COLUMNS;
  localparam int ColW     = $clog2(ColLimit);
  localparam int RowW     = $clog2(MAX_ROWS);
  localparam int RowsBits = $clog2(MAX_ROWS + 1);
  localparam int RowCmpW  = (RowsBits > CfgDataW) ? RowsBits : CfgDataW;
  localparam int PtrW     = $clog2(OutDepth);
  localparam int CntW     = $clog2(OutDepth + 1);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CfgDataW-1:0] grid_cols_q, grid_rows_q;
  logic                cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i &&
                       ((cfg_index_i == CFG_GRID_COLUMNS) || (cfg_index_i == CFG_GRID_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GridColumnsReset;
      grid_rows_q <= GridRowsReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_GRID_COLUMNS) begin
        grid_cols_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_GRID_ROWS) begin
        grid_rows_q <= cfg_data_i;
      end
    end
  end

  // Last column and last row in use, after clamping
  logic [ColW-1:0] cols_last;
  logic [RowW-1:0] rows_last;

  always_comb begin
    if (grid_cols_q == '0) begin
      cols_last = '0;
    end else if (grid_cols_q > CfgDataW'(ColLimit)) begin
      cols_last = ColW'(ColLimit - 1);
    end else begin
      cols_last = ColW'(grid_cols_q - CfgDataW'(1));
    end
  end

  always_comb begin
    if (grid_rows_q == '0) begin
      rows_last = '0;
    end else if (RowCmpW'(grid_rows_q) > RowCmpW'(MAX_ROWS)) begin
      rows_last = RowW'(MAX_ROWS - 1);
    end else begin
      rows_last = RowW'(grid_rows_q - CfgDataW'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Step sequencer: real cells, then a dead border row, then one tail step
  // ---------------------------------------------------------------------
  logic [1:0]      state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [CntW-1:0] fifo_cnt_q;
  logic            s1_valid_q;
  logic            credit;

  logic            s0_issue;
  logic            s0_cell;
  logic [ColW-1:0] s0_addr;
  logic            s0_top_en;
  logic            s0_mid_en;
  logic            s0_last;
  logic            in_accept;

  assign credit     = (fifo_cnt_q + CntW'(s1_valid_q)) < CntW'(OutDepth);
  assign in_stall_o = !((state_q == ST_RUN) && credit);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    s0_issue  = 1'b0;
    s0_cell   = 1'b0;
    s0_addr   = col_q;
    s0_top_en = 1'b0;
    s0_mid_en = 1'b0;
    s0_last   = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        s0_issue  = in_accept;
        s0_cell   = cell_alive_i;
        s0_top_en = row_q > RowW'(1);
        s0_mid_en = row_q != '0;
        if (in_accept) begin
          if (col_q == cols_last) begin
            col_d = '0;
            if (row_q == rows_last) begin
              row_d   = '0;
              state_d = ST_FLUSH;
            end else begin
              row_d = row_q + RowW'(1);
            end
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
      end
      ST_FLUSH: begin
        s0_issue  = credit;
        s0_top_en = rows_last != '0;
        s0_mid_en = 1'b1;
        if (credit) begin
          if (col_q == cols_last) begin
            col_d   = '0;
            state_d = ST_TAIL;
          end else begin
            col_d = col_q + ColW'(1);
          end
        end
      end
      ST_TAIL: begin
        s0_issue  = credit;
        s0_addr   = '0;
        s0_top_en = 1'b1;
        s0_mid_en = 1'b1;
        s0_last   = 1'b1;
        if (credit) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    // Restart the generation on any register write
    if (cfg_write) begin
      state_d = ST_RUN;
      col_d   = '0;
      row_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: entry c holds {row above, current row} at column c
  // ---------------------------------------------------------------------
  logic [1:0]      ram_rdata;
  logic [1:0]      ram_wdata;
  logic            s1_cell_q, s1_top_en_q, s1_mid_en_q, s1_last_q;
  logic [ColW-1:0] s1_addr_q;
  logic            fwd_q, fwd_d;
  logic [1:0]      fwd_data_q;

  lgs_ram #(
    .Width(2),
    .Depth(ColLimit)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(ram_wdata),
    .raddr_i(s0_addr),
    .rdata_o(ram_rdata)
  );

  // Forward the write of the step ahead when both touch the same column
  assign fwd_d = s0_issue && s1_valid_q && (s0_addr == s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= s0_issue;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cell_q   <= s0_cell;
    s1_addr_q   <= s0_addr;
    s1_top_en_q <= s0_top_en;
    s1_mid_en_q <= s0_mid_en;
    s1_last_q   <= s0_last;
    fwd_data_q  <= ram_wdata;
  end

  // ---------------------------------------------------------------------
  // Stage 1: window update, rule, tally
  // ---------------------------------------------------------------------
  logic [8:0]      window_q, window_d;
  logic [PopW-1:0] tally_q, tally_d;
  logic [1:0]      mem_word;
  logic [2:0]      col_bits;
  logic [8:0]      win_shift, emit_bits;
  logic            col0, emit, alive, push;
  logic [PopW-1:0] tally_sum;
  out_item_t       push_item;

  assign mem_word  = fwd_q ? fwd_data_q : ram_rdata;
  assign col_bits  = {s1_cell_q, s1_mid_en_q & mem_word[0], s1_top_en_q & mem_word[1]};
  assign ram_wdata = {mem_word[0], s1_cell_q};
  assign col0      = s1_addr_q == '0;
  assign win_shift = {col_bits, window_q[8:3]};
  // At column 0 the window still holds the previous row's end: close its right edge
  assign emit_bits = col0 ? {3'b000, window_q[8:3]} : win_shift;
  assign emit      = col0 ? s1_top_en_q : s1_mid_en_q;
  assign alive     = life_rule(emit_bits);
  assign tally_sum = tally_q + PopW'(alive);
  assign push      = s1_valid_q && emit;

  assign push_item.next_alive = alive;
  assign push_item.frame_last = s1_last_q;
  assign push_item.population = s1_last_q ? tally_sum : '0;

  always_comb begin
    window_d = window_q;
    tally_d  = tally_q;
    if (cfg_write) begin
      window_d = '0;
      tally_d  = '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        window_d = '0;
        tally_d  = '0;
      end else begin
        window_d = col0 ? {col_bits, 6'b000000} : win_shift;
        if (emit) begin
          tally_d = tally_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      tally_q  <= '0;
    end else begin
      window_q <= window_d;
      tally_q  <= tally_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output queue: decouples the engine from a stalling receiver
  // ---------------------------------------------------------------------
  out_item_t       fifo_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic            pop;
  out_item_t       head;

  assign out_valid_o = fifo_cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head        = fifo_q[rd_ptr_q];

  assign next_alive_o = head.next_alive;
  assign frame_last_o = head.frame_last;
  assign population_o = head.population;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + CntW'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fifo_cnt_q != CntW'(OutDepth))
    else $error("output queue overflow");

  a_tail_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q |-> emit)
    else $error("final step produced no result");

  a_pop_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> population_o == '0)
    else $error("population on a non-final item");

  a_flush_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (col_q == cols_last) && (row_q == rows_last) && !cfg_write
    |=> state_q == ST_FLUSH)
    else $error("no flush after last cell");
`endif

endmodule

// ----- design/lgs_ram.sv -----
module lgs_ram #(
  parameter int Width = 2,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
